@@ rtl/rfwg_pkg.sv @@
// Package for the rectangle fill write generator.
// Holds beat structs, command and status types, register indexes and helpers.
// No dependencies.
`timescale 1ns / 1ps

package rfwg_pkg;

    localparam int DIM_W      = 13;
    localparam int COORD_W    = 12;
    localparam int PITCH_W    = 16;
    localparam int OFS_W      = 28;
    localparam int COLOUR_W   = 32;
    localparam int BYTES_W    = 3;
    localparam int XOFS_W     = 14;
    localparam int Q_DEPTH    = 4;
    localparam int Q_PTR_W    = 2;
    localparam int Q_CNT_W    = 3;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [DIM_W-1:0] MAX_DIM = 13'd4096;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SCREEN_WIDTH  = 3'd0,
        CFG_SCREEN_HEIGHT = 3'd1,
        CFG_LINE_PITCH    = 3'd2,
        CFG_DEPTH_MODE    = 3'd3,
        CFG_FB_ENABLED    = 3'd4
    } t_cfg_idx;

    typedef enum logic [1:0] {
        DEPTH_NONE = 2'd0,
        DEPTH_16   = 2'd1,
        DEPTH_24   = 2'd2,
        DEPTH_32   = 2'd3
    } t_depth;

    typedef enum logic {
        ACT_START = 1'b0,
        ACT_TICK  = 1'b1
    } t_action;

    typedef struct packed {
        logic                  action;
        logic [COORD_W-1:0]    rect_x;
        logic [COORD_W-1:0]    rect_y;
        logic [DIM_W-1:0]      rect_w;
        logic [DIM_W-1:0]      rect_h;
        logic [COLOUR_W-1:0]   fill_value;
    } t_in_item;

    typedef struct packed {
        logic [OFS_W-1:0]      write_offset;
        logic [COLOUR_W-1:0]   write_data;
        logic [BYTES_W-1:0]    byte_count;
        logic                  last_write;
    } t_out_item;

    typedef struct packed {
        logic [DIM_W-1:0]      screen_width;
        logic [DIM_W-1:0]      screen_height;
        logic [PITCH_W-1:0]    line_pitch;
        t_depth                depth_mode;
        logic                  fb_enabled;
    } t_cfg;

    // Classified command passed from the front end to the walker
    typedef struct packed {
        t_action               kind;
        logic [OFS_W-1:0]      line_offset;
        logic [DIM_W-1:0]      clipped_w;
        logic [DIM_W-1:0]      clipped_h;
        logic [COLOUR_W-1:0]   colour;
        logic [BYTES_W-1:0]    bytes;
        logic [PITCH_W-1:0]    pitch;
    } t_cmd;

    typedef struct packed {
        logic                  empty;
        logic                  full;
        logic [Q_CNT_W-1:0]    count;
    } t_q_status;

    typedef struct packed {
        logic                  busy;
        logic [DIM_W-1:0]      row;
        logic [DIM_W-1:0]      col;
        logic [DIM_W-1:0]      clipped_w;
        logic [DIM_W-1:0]      clipped_h;
        logic [OFS_W-1:0]      line_offset;
        logic [OFS_W-1:0]      pixel_offset;
    } t_back_status;

    function automatic logic [DIM_W-1:0] limit_dim(input logic [DIM_W-1:0] v);
        return (v > MAX_DIM) ? MAX_DIM : v;
    endfunction

endpackage

@@ rtl/rect_fill_write_generator.sv @@
// Top level of the rectangle fill write generator.
// Holds the configuration registers and joins front end, queue and walker.
// Depends on rfwg_pkg, rfwg_front, rfwg_queue, rfwg_back.
`timescale 1ns / 1ps

// Takes one input beat per clock while o_in_stall is low and gives one
// pixel write beat per clock while i_out_stall is low. A start beat (action
// 0) is checked against the current configuration in the front end: it is
// dropped if the frame buffer is disabled, the depth mode is none, the
// width or height is zero or the origin is off-screen. Otherwise width and
// height are clipped to the screen (each screen dimension capped at 4096),
// the start offset y*pitch + x*bytes is formed by a multiply before the
// front-end register and an add after it, and the command joins a
// four-deep queue. The walker takes one command a cycle from the queue
// head unless a tick meets a stalled output; a tick (action 1) while a
// rectangle is open yields one write into the output register, in
// row-major order, with last_write on the final pixel. Ticks while idle and
// starts while busy give nothing. A tick passes the front-end register and
// the queue before its write is registered. Configuration is sampled as
// each start is accepted, so write it only while the block is idle.
module rect_fill_write_generator (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    input  rfwg_pkg::t_in_item                i_in_item,
    output logic                              o_in_stall,
    output logic                              o_out_valid,
    output rfwg_pkg::t_out_item               o_out_item,
    input  logic                              i_out_stall,
    input  logic                              i_cfg_we,
    input  logic [rfwg_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [rfwg_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    rfwg_pkg::t_cfg         r_cfg;
    logic                   push;
    rfwg_pkg::t_cmd         push_cmd;
    logic                   pop;
    rfwg_pkg::t_cmd         head;
    rfwg_pkg::t_q_status    q_status;
    rfwg_pkg::t_back_status back_status;

    // Configuration writes: decode the index, drop anything beyond the list
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            unique case (rfwg_pkg::t_cfg_idx'(i_cfg_index))
                rfwg_pkg::CFG_SCREEN_WIDTH: begin
                    r_cfg.screen_width <= i_cfg_data[rfwg_pkg::DIM_W-1:0];
                end
                rfwg_pkg::CFG_SCREEN_HEIGHT: begin
                    r_cfg.screen_height <= i_cfg_data[rfwg_pkg::DIM_W-1:0];
                end
                rfwg_pkg::CFG_LINE_PITCH: begin
                    r_cfg.line_pitch <= i_cfg_data;
                end
                rfwg_pkg::CFG_DEPTH_MODE: begin
                    r_cfg.depth_mode <= rfwg_pkg::t_depth'(i_cfg_data[1:0]);
                end
                rfwg_pkg::CFG_FB_ENABLED: begin
                    r_cfg.fb_enabled <= i_cfg_data[0];
                end
                default: begin
                end
            endcase
        end
    end

    // Front end: classify and hold one command for the queue
    rfwg_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_item  (i_in_item),
        .i_cfg      (r_cfg),
        .i_q_full   (q_status.full),
        .o_in_stall (o_in_stall),
        .o_push     (push),
        .o_push_cmd (push_cmd)
    );

    // Queue lets the front keep accepting while the output side is stalled
    rfwg_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_push_cmd (push_cmd),
        .i_pop      (pop),
        .o_head     (head),
        .o_status   (q_status)
    );

    // Walker: advance through the rectangle, one write per tick
    rfwg_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (head),
        .i_q_empty   (q_status.empty),
        .i_out_stall (i_out_stall),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .o_out_item  (o_out_item),
        .o_status    (back_status)
    );

    // Walk position stays inside the clipped rectangle
    a_walk_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        back_status.busy |-> (back_status.col < back_status.clipped_w)
                          && (back_status.row < back_status.clipped_h))
        else $error("walker position outside clipped rectangle");

    // First pixel of a row sits at the row's line offset
    a_row_start_offset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (back_status.busy && (back_status.col == '0))
            |-> (back_status.pixel_offset == back_status.line_offset))
        else $error("pixel offset differs from line offset at row start");

    // Input is held off only when the queue is full
    a_stall_means_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (q_status.count == rfwg_pkg::Q_CNT_W'(rfwg_pkg::Q_DEPTH)))
        else $error("input stalled with room in the queue");

    // Queue occupancy never passes its depth
    a_queue_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_status.count <= rfwg_pkg::Q_CNT_W'(rfwg_pkg::Q_DEPTH))
        else $error("queue count beyond depth");

endmodule

@@ rtl/rfwg_front.sv @@
// Front end: accepts input beats, checks and clips start commands.
// Drops rejected starts; registers the classified command for the queue.
// Depends on rfwg_pkg.
`timescale 1ns / 1ps

module rfwg_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  rfwg_pkg::t_in_item i_in_item,
    input  rfwg_pkg::t_cfg     i_cfg,
    input  logic               i_q_full,
    output logic               o_in_stall,
    output logic               o_push,
    output rfwg_pkg::t_cmd     o_push_cmd
);

    logic [rfwg_pkg::DIM_W-1:0]    sw;
    logic [rfwg_pkg::DIM_W-1:0]    sh;
    logic [rfwg_pkg::DIM_W:0]      x_end;
    logic [rfwg_pkg::DIM_W:0]      y_end;
    logic                          start_ok;
    logic                          keep;
    logic                          accept;
    logic [rfwg_pkg::DIM_W-1:0]    cw;
    logic [rfwg_pkg::DIM_W-1:0]    ch;
    logic [rfwg_pkg::BYTES_W-1:0]  bytes;
    logic [rfwg_pkg::COLOUR_W-1:0] colour;
    logic [rfwg_pkg::OFS_W-1:0]    prod_y;
    logic [rfwg_pkg::XOFS_W-1:0]   prod_x;

    logic                          r_valid;
    logic                          n_valid;
    rfwg_pkg::t_action             r_kind;
    logic [rfwg_pkg::OFS_W-1:0]    r_prod_y;
    logic [rfwg_pkg::XOFS_W-1:0]   r_prod_x;
    logic [rfwg_pkg::DIM_W-1:0]    r_cw;
    logic [rfwg_pkg::DIM_W-1:0]    r_ch;
    logic [rfwg_pkg::COLOUR_W-1:0] r_colour;
    logic [rfwg_pkg::BYTES_W-1:0]  r_bytes;
    logic [rfwg_pkg::PITCH_W-1:0]  r_pitch;

    always_comb begin
        sw    = rfwg_pkg::limit_dim(i_cfg.screen_width);
        sh    = rfwg_pkg::limit_dim(i_cfg.screen_height);
        x_end = {2'b00, i_in_item.rect_x} + {1'b0, i_in_item.rect_w};
        y_end = {2'b00, i_in_item.rect_y} + {1'b0, i_in_item.rect_h};
        start_ok = i_cfg.fb_enabled
                   && (i_in_item.rect_w != '0) && (i_in_item.rect_h != '0)
                   && (i_cfg.depth_mode != rfwg_pkg::DEPTH_NONE)
                   && ({1'b0, i_in_item.rect_x} < sw)
                   && ({1'b0, i_in_item.rect_y} < sh);
        cw = (x_end > {1'b0, sw}) ? (sw - {1'b0, i_in_item.rect_x}) : i_in_item.rect_w;
        ch = (y_end > {1'b0, sh}) ? (sh - {1'b0, i_in_item.rect_y}) : i_in_item.rect_h;
        bytes = {1'b0, i_cfg.depth_mode} + 3'd1;
        unique case (i_cfg.depth_mode)
            rfwg_pkg::DEPTH_16: colour = {16'h0000, i_in_item.fill_value[15:0]};
            rfwg_pkg::DEPTH_24: colour = {8'h00, i_in_item.fill_value[23:0]};
            default:            colour = i_in_item.fill_value;
        endcase
        prod_y = {{(rfwg_pkg::OFS_W-rfwg_pkg::COORD_W){1'b0}}, i_in_item.rect_y}
                 * {{(rfwg_pkg::OFS_W-rfwg_pkg::PITCH_W){1'b0}}, i_cfg.line_pitch};
        prod_x = {2'b00, i_in_item.rect_x}
                 * {{(rfwg_pkg::XOFS_W-rfwg_pkg::BYTES_W){1'b0}}, bytes};
        keep   = (i_in_item.action == rfwg_pkg::ACT_TICK) || start_ok;
    end

    assign o_in_stall = r_valid && i_q_full;
    assign accept     = i_in_valid && !o_in_stall;
    assign o_push     = r_valid && !i_q_full;

    always_comb begin
        n_valid = r_valid;
        if (accept) begin
            n_valid = keep;
        end else if (o_push) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_kind   <= rfwg_pkg::t_action'(i_in_item.action);
            r_prod_y <= prod_y;
            r_prod_x <= prod_x;
            r_cw     <= cw;
            r_ch     <= ch;
            r_colour <= colour;
            r_bytes  <= bytes;
            r_pitch  <= i_cfg.line_pitch;
        end
    end

    always_comb begin
        o_push_cmd.kind        = r_kind;
        o_push_cmd.line_offset = r_prod_y
                                 + {{(rfwg_pkg::OFS_W-rfwg_pkg::XOFS_W){1'b0}}, r_prod_x};
        o_push_cmd.clipped_w   = r_cw;
        o_push_cmd.clipped_h   = r_ch;
        o_push_cmd.colour      = r_colour;
        o_push_cmd.bytes       = r_bytes;
        o_push_cmd.pitch       = r_pitch;
    end

endmodule

@@ rtl/rfwg_queue.sv @@
// Short command queue between the front end and the walker.
// Depends on rfwg_pkg.
`timescale 1ns / 1ps

module rfwg_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  rfwg_pkg::t_cmd      i_push_cmd,
    input  logic                i_pop,
    output rfwg_pkg::t_cmd      o_head,
    output rfwg_pkg::t_q_status o_status
);

    rfwg_pkg::t_cmd                r_mem [rfwg_pkg::Q_DEPTH];
    logic [rfwg_pkg::Q_PTR_W-1:0]  r_wr_ptr;
    logic [rfwg_pkg::Q_PTR_W-1:0]  r_rd_ptr;
    logic [rfwg_pkg::Q_CNT_W-1:0]  r_count;
    logic [rfwg_pkg::Q_CNT_W-1:0]  n_count;

    assign o_head         = r_mem[r_rd_ptr];
    assign o_status.empty = (r_count == '0);
    assign o_status.full  = (r_count == rfwg_pkg::Q_CNT_W'(rfwg_pkg::Q_DEPTH));
    assign o_status.count = r_count;

    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_push_cmd;
        end
    end

endmodule

@@ rtl/rfwg_back.sv @@
// Back end: walks the latched rectangle and issues one pixel write per tick.
// Holds the output register. Depends on rfwg_pkg.
`timescale 1ns / 1ps

module rfwg_back (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  rfwg_pkg::t_cmd         i_head,
    input  logic                   i_q_empty,
    input  logic                   i_out_stall,
    output logic                   o_pop,
    output logic                   o_out_valid,
    output rfwg_pkg::t_out_item    o_out_item,
    output rfwg_pkg::t_back_status o_status
);

    logic                          r_busy;
    logic                          n_busy;
    logic                          r_out_valid;
    logic                          n_out_valid;
    rfwg_pkg::t_out_item           r_out;
    rfwg_pkg::t_out_item           n_out;
    logic [rfwg_pkg::DIM_W-1:0]    r_row,  n_row;
    logic [rfwg_pkg::DIM_W-1:0]    r_col,  n_col;
    logic [rfwg_pkg::DIM_W-1:0]    r_cw,   n_cw;
    logic [rfwg_pkg::DIM_W-1:0]    r_ch,   n_ch;
    logic [rfwg_pkg::OFS_W-1:0]    r_line, n_line;
    logic [rfwg_pkg::OFS_W-1:0]    r_pix,  n_pix;
    logic [rfwg_pkg::COLOUR_W-1:0] r_colour, n_colour;
    logic [rfwg_pkg::BYTES_W-1:0]  r_bytes,  n_bytes;
    logic [rfwg_pkg::PITCH_W-1:0]  r_pitch,  n_pitch;

    logic out_free;
    logic row_end;
    logic last;

    assign out_free = !r_out_valid || !i_out_stall;
    assign o_pop    = !i_q_empty
                      && ((i_head.kind == rfwg_pkg::ACT_START) || !r_busy || out_free);
    assign row_end  = ({1'b0, r_col} + 1'b1) >= {1'b0, r_cw};
    assign last     = row_end && (({1'b0, r_row} + 1'b1) >= {1'b0, r_ch});

    always_comb begin
        n_busy      = r_busy;
        n_out_valid = r_out_valid && i_out_stall;
        n_out       = r_out;
        n_row       = r_row;
        n_col       = r_col;
        n_cw        = r_cw;
        n_ch        = r_ch;
        n_line      = r_line;
        n_pix       = r_pix;
        n_colour    = r_colour;
        n_bytes     = r_bytes;
        n_pitch     = r_pitch;
        if (o_pop) begin
            if (i_head.kind == rfwg_pkg::ACT_START) begin
                // a start while busy has no effect
                if (!r_busy) begin
                    n_busy   = 1'b1;
                    n_row    = '0;
                    n_col    = '0;
                    n_cw     = i_head.clipped_w;
                    n_ch     = i_head.clipped_h;
                    n_line   = i_head.line_offset;
                    n_pix    = i_head.line_offset;
                    n_colour = i_head.colour;
                    n_bytes  = i_head.bytes;
                    n_pitch  = i_head.pitch;
                end
            end else if (r_busy) begin
                n_out_valid        = 1'b1;
                n_out.write_offset = r_pix;
                n_out.write_data   = r_colour;
                n_out.byte_count   = r_bytes;
                n_out.last_write   = last;
                priority if (last) begin
                    n_busy = 1'b0;
                end else if (row_end) begin
                    n_col  = '0;
                    n_row  = r_row + 1'b1;
                    n_line = r_line
                             + {{(rfwg_pkg::OFS_W-rfwg_pkg::PITCH_W){1'b0}}, r_pitch};
                    n_pix  = n_line;
                end else begin
                    n_col = r_col + 1'b1;
                    n_pix = r_pix
                            + {{(rfwg_pkg::OFS_W-rfwg_pkg::BYTES_W){1'b0}}, r_bytes};
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_busy      <= n_busy;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out    <= n_out;
        r_row    <= n_row;
        r_col    <= n_col;
        r_cw     <= n_cw;
        r_ch     <= n_ch;
        r_line   <= n_line;
        r_pix    <= n_pix;
        r_colour <= n_colour;
        r_bytes  <= n_bytes;
        r_pitch  <= n_pitch;
    end

    assign o_out_valid           = r_out_valid;
    assign o_out_item            = r_out;
    assign o_status.busy         = r_busy;
    assign o_status.row          = r_row;
    assign o_status.col          = r_col;
    assign o_status.clipped_w    = r_cw;
    assign o_status.clipped_h    = r_ch;
    assign o_status.line_offset  = r_line;
    assign o_status.pixel_offset = r_pix;

endmodule
